[hw/rtl/led_seq_pkg.sv]
// Shared types and constants for the LED pattern sequencer.
// No dependencies; used by led_seq_step and led_pattern_sequencer.
`default_nettype none

package led_seq_pkg;

  localparam int unsigned PeriodW = 10;
  localparam int unsigned PosW    = 3;
  localparam int unsigned LedW    = 8;

  localparam logic [PeriodW-1:0] PERIOD_RESET = 10'd100;
  localparam logic [PeriodW-1:0] COUNT_MAX    = 10'd1023;

  localparam logic [LedW-1:0] LED_LSB      = 8'h01;
  localparam logic [LedW-1:0] LED_MSB      = 8'h80;
  localparam logic [LedW-1:0] LED_MID_HIGH = 8'h10;
  localparam logic [LedW-1:0] LED_MID_LOW  = 8'h08;

  typedef enum logic [2:0] {
    MODE_SHIFT_LEFT  = 3'd0,
    MODE_SHIFT_RIGHT = 3'd1,
    MODE_FILL_LEFT   = 3'd2,
    MODE_OFF_A       = 3'd3,
    MODE_FILL_WRAP   = 3'd4,
    MODE_OFF_B       = 3'd5,
    MODE_FLOWER_OPEN = 3'd6,
    MODE_FLOWER_CLOSE = 3'd7
  } mode_t;

  typedef struct packed {
    logic [PeriodW-1:0] count;
    mode_t              mode;
    logic [PosW-1:0]    pos;
    logic [LedW-1:0]    port;
  } seq_state_t;

endpackage

`default_nettype wire

[hw/rtl/led_seq_step.sv]
// Next-state logic of the LED pattern sequencer for one request.
// Depends on led_seq_pkg.
`default_nettype none

module led_seq_step (
  input  led_seq_pkg::seq_state_t              cur,
  input  logic                                 tick,
  input  logic [led_seq_pkg::PeriodW-1:0]      period,
  output led_seq_pkg::seq_state_t              nxt
);
  import led_seq_pkg::*;

  logic [PeriodW-1:0] period_eff;
  logic [PeriodW-1:0] count1;
  mode_t              mode1;
  logic [LedW-1:0]    port1;
  logic [PosW-1:0]    p;
  logic [PosW-1:0]    pos_next;
  logic [LedW-1:0]    port_step;
  logic [LedW-1:0]    bloom;
  logic [LedW-1:0]    close_mask;

  always_comb begin
    period_eff = (period == '0) ? {{(PeriodW-1){1'b0}}, 1'b1} : period;

    // saturating tick counter
    count1 = (tick && (cur.count != COUNT_MAX)) ? cur.count + 1'b1 : cur.count;

    // all-off modes clear the port and move on without waiting
    mode1 = cur.mode;
    port1 = cur.port;
    if (cur.mode == MODE_OFF_A || cur.mode == MODE_OFF_B) begin
      port1 = '0;
      mode1 = mode_t'(cur.mode + 3'd1);
    end

    p          = cur.pos;
    pos_next   = p + 1'b1;
    bloom      = (LED_MID_HIGH << p) | (LED_MID_LOW >> p);
    close_mask = (LED_MSB >> p) | (LED_LSB << p);
    case (mode1)
      MODE_SHIFT_LEFT:   port_step = LED_LSB << p;
      MODE_SHIFT_RIGHT:  port_step = LED_MSB >> p;
      MODE_FILL_LEFT:    port_step = port1 | (LED_LSB << p);
      MODE_FILL_WRAP: begin
        port_step = port1 | (LED_LSB << p);
        pos_next  = p - 1'b1;
      end
      MODE_FLOWER_OPEN:  port_step = port1 | bloom;
      MODE_FLOWER_CLOSE: port_step = port1 & ~close_mask;
      default:           port_step = '0;
    endcase

    nxt.count = count1;
    nxt.mode  = mode1;
    nxt.pos   = cur.pos;
    nxt.port  = port1;
    if (count1 >= period_eff) begin
      nxt.count = '0;
      nxt.port  = port_step;
      nxt.pos   = pos_next;
      if (pos_next == '0) begin
        nxt.mode = mode_t'(mode1 + 3'd1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/led_pattern_sequencer.sv]
// Top level of the 8-LED chaser pattern sequencer.
// Depends on led_seq_pkg and led_seq_step.
`default_nettype none

// Eight-LED chaser paced by millisecond ticks. Each request on the tick
// channel carries one bit (1 = a millisecond elapsed) and yields exactly one
// result on the led channel: the LED drive bits after that request. When the
// tick count reaches step_period_ms (0 acts as 1), the current mode takes one
// step; after eight steps the mode advances through shift left, shift right,
// fill left, off, fill 0,7,6..1, off, flower open, flower close. Off modes
// clear the LEDs and advance on the next request without waiting. The block
// takes one request per clock unless the output is stalled: a request is
// registered, then the state update and result land in the output register;
// a stalled output register holds only the stage behind it. step_period_ms
// must be written through step_period_ms_we while idle, which the block does
// not enforce; reset value is 100, reset mode is shift right with LEDs off.
module led_pattern_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             tick_valid,
  output logic                             tick_stall,
  input  logic                             tick,
  // result channel
  output logic                             led_valid,
  input  logic                             led_stall,
  output logic [led_seq_pkg::LedW-1:0]     led_pattern,
  // configuration
  input  logic                             step_period_ms_we,
  input  logic [led_seq_pkg::PeriodW-1:0]  step_period_ms
);
  import led_seq_pkg::*;

  logic [PeriodW-1:0] period;
  seq_state_t         state;
  seq_state_t         state_next;

  // input register
  logic in_valid;
  logic in_tick;

  // the output register can take a new result this cycle
  logic advance;

  assign advance    = !(led_valid && led_stall);
  assign tick_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (step_period_ms_we) begin
      period <= step_period_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!tick_stall) begin
      in_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!tick_stall && tick_valid) begin
      in_tick <= tick;
    end
  end

  led_seq_step u_step (
    .cur    (state),
    .tick   (in_tick),
    .period (period),
    .nxt    (state_next)
  );

  // state and output register move together, once per registered request
  always_ff @(posedge clk) begin
    if (rst) begin
      state.count <= '0;
      state.mode  <= MODE_SHIFT_RIGHT;
      state.pos   <= '0;
      state.port  <= '0;
      led_valid   <= 1'b0;
    end else if (advance) begin
      led_valid <= in_valid;
      if (in_valid) begin
        state <= state_next;
      end
    end
  end

  assign led_pattern = state.port;

endmodule

`default_nettype wire

[hw/rtl/led_seq_checker.sv]
// Port-level checks for the LED pattern sequencer, and the bind to it.
// Depends on led_pattern_sequencer's ports only.
`default_nettype none

module led_seq_checker (
  input logic       clk,
  input logic       rst,
  input logic       tick_valid,
  input logic       tick_stall,
  input logic       led_valid,
  input logic       led_stall,
  input logic [7:0] led_pattern
);

  // a stalled result stays offered
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    led_valid && led_stall |=> led_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    led_valid && led_stall |=> $stable(led_pattern))
    else $error("result changed while stalled");

  // empty output register never pushes back on requests
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !led_valid |-> !tick_stall)
    else $error("request stalled with empty output");

  // an accepted request reaches the output register if the output was empty once the request was registered
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !tick_stall) ##1 !led_valid |=> led_valid)
    else $error("request lost");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !led_valid)
    else $error("result present after reset");

endmodule

bind led_pattern_sequencer led_seq_checker u_led_seq_checker (
  .clk         (clk),
  .rst         (rst),
  .tick_valid  (tick_valid),
  .tick_stall  (tick_stall),
  .led_valid   (led_valid),
  .led_stall   (led_stall),
  .led_pattern (led_pattern)
);

`default_nettype wire
